FILE: rtl/vwbs_pkg.sv
// vwbs_pkg: shared types, codes and constants for the voice wave buffer sequencer
// no dependencies
package vwbs_pkg;

    localparam int SLOTS_DEF    = 4;
    localparam int CHANNELS_DEF = 6;
    localparam int ADPCM_FRAME_SAMPLES = 14;
    localparam int ADPCM_FRAME_BYTES   = 8;

    localparam logic [1:0] REQ_UPDATE = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_GEN    = 2'd2;
    localparam logic [1:0] REQ_NOP    = 2'd3;

    localparam logic [1:0] PS_STARTED = 2'd0;
    localparam logic [1:0] PS_STOPPED = 2'd1;
    localparam logic [1:0] PS_REQSTOP = 2'd2;
    localparam logic [1:0] PS_PAUSED  = 2'd3;

    localparam logic [1:0] PLAY_START = 2'd0;
    localparam logic [1:0] PLAY_STOP  = 2'd1;
    localparam logic [1:0] PLAY_PAUSE = 2'd2;

    localparam logic [1:0] FMT_PCM16 = 2'd0;
    localparam logic [1:0] FMT_FLOAT = 2'd1;
    localparam logic [1:0] FMT_ADPCM = 2'd2;
    localparam logic [1:0] FMT_OTHER = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_SKIPPED = 2'd2;

    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [1:0] CFG_SAMPLE_FORMAT = 2'd1;
    localparam logic [1:0] CFG_FLUSH_ENABLE  = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // capture input word
        logic do_update;
        logic chk_start;  // compute byte position of start offset
        logic chk_end;    // compute byte position of end offset
        logic do_write;   // commit slot write using check result
        logic do_fresh;   // clear driven channels
        logic flush_step; // retire one pending slot
        logic walk_start; // rewind slot cursor for the slot walk
        logic gen_slot;   // started or request stop handling of one slot
        logic gen_final;  // finalize generate
        logic emit;       // load output register
    } vwbs_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       fresh;
        logic       flush_left; // pending flush nonzero
        logic       last_slot;  // slot cursor at last slot
    } vwbs_stat_t;

    // adpcm extra bytes for a remainder 0..13
    function automatic logic [3:0] adpcm_extra(input logic [3:0] r);
        logic [3:0] e;
        begin
            e = (r == 4'd0) ? 4'd0 : 4'((r >> 1) + 4'd1 + {3'd0, r[0]});
            return e;
        end
    endfunction

endpackage

FILE: rtl/vwbs_ctrl.sv
// vwbs_ctrl: sequencing state machine for one request word
// depends on vwbs_pkg
module vwbs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  vwbs_pkg::vwbs_stat_t stat,
    output vwbs_pkg::vwbs_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_WRT   = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;
    localparam logic [2:0] S_GSLOT = 3'd5;
    localparam logic [2:0] S_GFIN  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;

    assign s_ready = (state_reg == S_IDLE) && (!mvalid_reg || m_ready);
    assign m_valid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg;
        cmd         = '0;
        if (mvalid_reg && m_ready) begin
            mvalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                unique case (stat.req_type)
                    vwbs_pkg::REQ_UPDATE: begin
                        cmd.do_update = 1'b1;
                        cmd.emit      = 1'b1;
                        mvalid_next   = 1'b1;
                        state_next    = S_IDLE;
                    end
                    vwbs_pkg::REQ_WRITE: begin
                        cmd.chk_start = 1'b1;
                        state_next    = S_CHK;
                    end
                    vwbs_pkg::REQ_GEN: begin
                        cmd.do_fresh = stat.fresh;
                        state_next   = S_FLUSH;
                    end
                    default: begin
                        cmd.emit    = 1'b1;
                        mvalid_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                endcase
            end
            S_CHK: begin
                cmd.chk_end = 1'b1;
                state_next  = S_WRT;
            end
            S_WRT: begin
                cmd.do_write = 1'b1;
                cmd.emit     = 1'b1;
                mvalid_next  = 1'b1;
                state_next   = S_IDLE;
            end
            S_FLUSH: begin
                if (stat.flush_left) begin
                    cmd.flush_step = 1'b1;
                end else begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_GSLOT;
                end
            end
            S_GSLOT: begin
                cmd.gen_slot = 1'b1;
                if (stat.last_slot) begin
                    state_next = S_GFIN;
                end
            end
            S_GFIN: begin
                cmd.gen_final = 1'b1;
                cmd.emit      = 1'b1;
                mvalid_next   = 1'b1;
                state_next    = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

FILE: rtl/vwbs_datapath.sv
// vwbs_datapath: voice state, slot ring, channel registers and offset check
// depends on vwbs_pkg
module vwbs_datapath #(
    parameter int SLOTS    = vwbs_pkg::SLOTS_DEF,
    parameter int CHANNELS = vwbs_pkg::CHANNELS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  vwbs_pkg::vwbs_cmd_t  cmd,
    output vwbs_pkg::vwbs_stat_t stat,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [2:0]           cfg_data,
    input  logic [1:0]           s_req_type,
    input  logic [1:0]           s_play_request,
    input  logic [7:0]           s_flush_add,
    input  logic [1:0]           s_head_index,
    input  logic                 s_new_voice,
    input  logic [1:0]           s_slot,
    input  logic signed [31:0]   s_first_sample,
    input  logic signed [31:0]   s_last_sample,
    input  logic [31:0]          s_buffer_size,
    input  logic                 s_already_sent,
    output logic [1:0]           m_status,
    output logic                 m_active,
    output logic [1:0]           m_play_state_now,
    output logic [31:0]          m_consumed_count
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // ring slot of a 2-bit index, one compare and subtract
    function automatic logic [SW-1:0] slot_mod(input logic [1:0] x);
        return (32'(x) >= SLOTS) ? SW'(32'(x) - SLOTS) : SW'(x);
    endfunction

    logic [2:0] chan_count_reg;
    logic [1:0] fmt_reg;
    logic       flush_en_reg;

    logic [1:0]  req_reg;
    logic [1:0]  play_req_reg;
    logic [7:0]  flush_add_reg;
    logic [1:0]  head_in_reg;
    logic        new_voice_reg;
    logic [1:0]  slot_in_reg;
    logic signed [31:0] start_reg;
    logic signed [31:0] end_reg;
    logic [31:0] size_reg;
    logic        sent_in_reg;

    logic [1:0]  ps_reg;
    logic [1:0]  prior_ps_reg;
    logic [SLOTS-1:0] sent_reg;
    logic [SLOTS-1:0] cvalid_reg [CHANNELS];
    logic [SW-1:0]    cring_reg  [CHANNELS];
    logic [31:0]      ccons_reg  [CHANNELS];
    logic [7:0]  pend_reg;
    logic [SW-1:0] head_reg;
    logic        fresh_reg;
    logic [SW-1:0] cur_reg;   // ring cursor during flush and slot walk
    logic        bad_reg;     // offset check failed
    logic        act_reg;

    logic [1:0]  out_status_reg;
    logic        out_active_reg;
    logic [1:0]  out_ps_reg;
    logic [31:0] out_cons_reg;

    logic [3:0] n_drv;
    logic [CHANNELS-1:0] drv;
    logic [31:0] off_sel;
    logic [34:0] bpos;
    logic [31:0] q14;
    logic [3:0]  r14;
    logic [63:0] qprod;
    logic [SW-1:0] cur_inc;
    logic [8:0]  pend_sum;

    assign n_drv = ({1'b0, chan_count_reg} > 4'(CHANNELS)) ? 4'(CHANNELS)
                                                            : {1'b0, chan_count_reg};
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            drv[c] = (4'(c) < n_drv);
        end
    end

    assign cur_inc = (32'(cur_reg) == 32'(SLOTS - 1)) ? '0 : SW'(cur_reg + 1'b1);
    assign pend_sum = {1'b0, pend_reg} + {1'b0, flush_add_reg};

    // byte position via reciprocal divide by 14, exact below 2^31
    assign off_sel = cmd.chk_start ? start_reg : end_reg;
    assign qprod = {32'd0, off_sel} * 64'h0000_0000_9249_2493;
    always_comb begin
        logic [31:0] q;
        logic [35:0] rem;
        q   = 32'(qprod >> 35);
        rem = {4'd0, off_sel} - 36'(q) * 36'd14;
        q14 = q;
        r14 = rem[3:0];
    end
    always_comb begin
        unique case (fmt_reg)
            vwbs_pkg::FMT_PCM16: bpos = {2'd0, off_sel, 1'b0};
            vwbs_pkg::FMT_FLOAT: bpos = {1'b0, off_sel, 2'b0};
            vwbs_pkg::FMT_ADPCM: bpos = {q14, 3'd0} + 35'(vwbs_pkg::adpcm_extra(r14));
            default:             bpos = '0;
        endcase
    end

    assign stat.req_type   = req_reg;
    assign stat.fresh      = fresh_reg;
    assign stat.flush_left = (pend_reg != 8'd0);
    assign stat.last_slot  = (32'(cur_reg) == 32'(SLOTS - 1));

    always_ff @(posedge aclk) begin
        if (cfg_valid) begin
            unique case (cfg_index)
                vwbs_pkg::CFG_CHANNEL_COUNT: chan_count_reg <= cfg_data;
                vwbs_pkg::CFG_SAMPLE_FORMAT: fmt_reg <= cfg_data[1:0];
                vwbs_pkg::CFG_FLUSH_ENABLE:  flush_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
        if (cmd.load) begin
            req_reg       <= s_req_type;
            play_req_reg  <= s_play_request;
            flush_add_reg <= s_flush_add;
            head_in_reg   <= s_head_index;
            new_voice_reg <= s_new_voice;
            slot_in_reg   <= s_slot;
            start_reg     <= s_first_sample;
            end_reg       <= s_last_sample;
            size_reg      <= s_buffer_size;
            sent_in_reg   <= s_already_sent;
            bad_reg       <= 1'b0;
            act_reg       <= 1'b0;
        end
        if (cmd.chk_start || cmd.chk_end) begin
            if (off_sel[31] ||
                (fmt_reg != vwbs_pkg::FMT_OTHER && bpos > {3'd0, size_reg})) begin
                bad_reg <= 1'b1;
            end
        end
        if (cmd.do_update) begin
            prior_ps_reg <= ps_reg;
            unique case (play_req_reg)
                vwbs_pkg::PLAY_START: ps_reg <= vwbs_pkg::PS_STARTED;
                vwbs_pkg::PLAY_STOP:  if (ps_reg != vwbs_pkg::PS_STOPPED) ps_reg <= vwbs_pkg::PS_REQSTOP;
                vwbs_pkg::PLAY_PAUSE: ps_reg <= vwbs_pkg::PS_PAUSED;
                default: ;
            endcase
            head_reg <= slot_mod(head_in_reg);
            if (flush_en_reg) begin
                pend_reg <= pend_sum[8] ? 8'hFF : pend_sum[7:0];
            end
            if (new_voice_reg) begin
                sent_reg  <= '1;
                fresh_reg <= 1'b1;
                for (int c = 0; c < CHANNELS; c++) begin
                    if (drv[c]) cvalid_reg[c] <= '0;
                end
            end
        end
        if (cmd.do_write && !sent_in_reg && !bad_reg) begin
            sent_reg[slot_mod(slot_in_reg)] <= 1'b0;
        end
        if (cmd.do_fresh) begin
            fresh_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                if (drv[c]) begin
                    cvalid_reg[c] <= '0;
                    cring_reg[c]  <= '0;
                    ccons_reg[c]  <= '0;
                end
            end
        end
        if (cmd.load) begin
            cur_reg <= head_reg;
        end
        if (cmd.flush_step) begin
            sent_reg[cur_reg] <= 1'b1;
            for (int c = 0; c < CHANNELS; c++) begin
                if (drv[c]) begin
                    if (cring_reg[c] == cur_reg) begin
                        cring_reg[c] <= cur_inc;
                        ccons_reg[c] <= ccons_reg[c] + 32'd1;
                    end
                    cvalid_reg[c][cur_reg] <= 1'b0;
                end
            end
            pend_reg <= pend_reg - 8'd1;
            cur_reg  <= cur_inc;
        end
        if (cmd.walk_start) begin
            cur_reg <= '0;
        end
        if (cmd.gen_slot) begin
            if (ps_reg == vwbs_pkg::PS_STARTED) begin
                if (!sent_reg[cur_reg]) begin
                    sent_reg[cur_reg] <= 1'b1;
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (drv[c]) cvalid_reg[c][cur_reg] <= 1'b1;
                    end
                end
            end else if (ps_reg == vwbs_pkg::PS_REQSTOP) begin
                sent_reg[cur_reg] <= 1'b1;
                for (int c = 0; c < CHANNELS; c++) begin
                    if (drv[c]) begin
                        if (cvalid_reg[c][cur_reg]) begin
                            cring_reg[c] <= (32'(cring_reg[c]) == 32'(SLOTS - 1)) ? '0
                                            : SW'(cring_reg[c] + 1'b1);
                            ccons_reg[c] <= ccons_reg[c] + 32'd1;
                        end
                        cvalid_reg[c][cur_reg] <= 1'b0;
                    end
                end
            end
            cur_reg <= cur_inc;
        end
        if (cmd.gen_final) begin
            if (ps_reg == vwbs_pkg::PS_STARTED) begin
                act_reg <= (cvalid_reg[0] != '0);
            end else begin
                act_reg <= (prior_ps_reg == vwbs_pkg::PS_STARTED);
                if (ps_reg == vwbs_pkg::PS_REQSTOP) ps_reg <= vwbs_pkg::PS_STOPPED;
            end
        end
        if (!aresetn) begin
            chan_count_reg <= 3'd1;
            fmt_reg        <= vwbs_pkg::FMT_PCM16;
            flush_en_reg   <= 1'b1;
            ps_reg         <= vwbs_pkg::PS_STOPPED;
            prior_ps_reg   <= vwbs_pkg::PS_STOPPED;
            sent_reg       <= '1;
            pend_reg       <= '0;
            head_reg       <= '0;
            fresh_reg      <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                cvalid_reg[c] <= '0;
                cring_reg[c]  <= '0;
                ccons_reg[c]  <= '0;
            end
        end
    end

    // result word
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            if (req_reg == vwbs_pkg::REQ_WRITE) begin
                out_status_reg <= sent_in_reg ? vwbs_pkg::ST_SKIPPED :
                                  (bad_reg ? vwbs_pkg::ST_INVALID : vwbs_pkg::ST_OK);
            end else begin
                out_status_reg <= vwbs_pkg::ST_OK;
            end
        end
    end

    // active, state and count are sampled in the cycle after emit so all updates land
    logic emit_d_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_d_reg <= 1'b0;
        end else begin
            emit_d_reg <= cmd.emit;
        end
    end

    always_comb begin
        m_status         = out_status_reg;
        m_active         = out_active_reg;
        m_play_state_now = out_ps_reg;
        m_consumed_count = out_cons_reg;
        if (emit_d_reg) begin
            m_active         = (req_reg == vwbs_pkg::REQ_GEN) ? act_reg : 1'b0;
            m_play_state_now = ps_reg;
            m_consumed_count = fresh_reg ? 32'd0 : ccons_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_d_reg) begin
            out_active_reg <= m_active;
            out_ps_reg     <= m_play_state_now;
            out_cons_reg   <= m_consumed_count;
        end
    end

endmodule

FILE: rtl/voice_wave_buffer_sequencer.sv
// voice_wave_buffer_sequencer: top level, joins controller and datapath
// depends on vwbs_pkg, vwbs_ctrl, vwbs_datapath
//
// channel   direction  handshake           payload
// s_        in         s_valid/s_ready     request word, ten fields
// m_        out        m_valid/m_ready     result word, four fields
// cfg_      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// update and no-op words end at dispatch; slot writes check start and end offsets
// before the commit; generate clears a fresh voice, then walks flushes and slots
// results sit in an output register; a new word is taken once the result is taken
// synchronous active-low reset restores the voice to stopped with all slots sent
module voice_wave_buffer_sequencer #(
    parameter int SLOTS    = vwbs_pkg::SLOTS_DEF,
    parameter int CHANNELS = vwbs_pkg::CHANNELS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [2:0]         cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic [1:0]         s_play_request,
    input  logic [7:0]         s_flush_add,
    input  logic [1:0]         s_head_index,
    input  logic               s_new_voice,
    input  logic [1:0]         s_slot,
    input  logic signed [31:0] s_first_sample,
    input  logic signed [31:0] s_last_sample,
    input  logic [31:0]        s_buffer_size,
    input  logic               s_already_sent,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic               m_active,
    output logic [1:0]         m_play_state_now,
    output logic [31:0]        m_consumed_count
);

    vwbs_pkg::vwbs_cmd_t  cmd;
    vwbs_pkg::vwbs_stat_t stat;

    assign cfg_ready = 1'b1;

    vwbs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    vwbs_datapath #(
        .SLOTS    (SLOTS),
        .CHANNELS (CHANNELS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_req_type       (s_req_type),
        .s_play_request   (s_play_request),
        .s_flush_add      (s_flush_add),
        .s_head_index     (s_head_index),
        .s_new_voice      (s_new_voice),
        .s_slot           (s_slot),
        .s_first_sample   (s_first_sample),
        .s_last_sample    (s_last_sample),
        .s_buffer_size    (s_buffer_size),
        .s_already_sent   (s_already_sent),
        .m_status         (m_status),
        .m_active         (m_active),
        .m_play_state_now (m_play_state_now),
        .m_consumed_count (m_consumed_count)
    );

endmodule

FILE: tb/voice_wave_buffer_sequencer_tb.sv
// voice_wave_buffer_sequencer_tb: self-checking bench for the voice wave buffer sequencer
// predicts every result word from a behavioral copy of the voice state
// depends on vwbs_pkg and voice_wave_buffer_sequencer
`timescale 1ns / 1ps

module voice_wave_buffer_sequencer_tb;

    localparam int NSLOT = vwbs_pkg::SLOTS_DEF;
    localparam int NCHAN = vwbs_pkg::CHANNELS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [1:0]  play_request;
        logic [7:0]  flush_add;
        logic [1:0]  head_index;
        logic        new_voice;
        logic [1:0]  slot;
        logic [31:0] first_sample;
        logic [31:0] last_sample;
        logic [31:0] buffer_size;
        logic        already_sent;
    } voice_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        active;
        logic [1:0]  play_state_now;
        logic [31:0] consumed_count;
    } voice_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [2:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_req_type = '0;
    logic [1:0] s_play_request = '0;
    logic [7:0] s_flush_add = '0;
    logic [1:0] s_head_index = '0;
    logic s_new_voice = 1'b0;
    logic [1:0] s_slot = '0;
    logic signed [31:0] s_first_sample = '0;
    logic signed [31:0] s_last_sample = '0;
    logic [31:0] s_buffer_size = '0;
    logic s_already_sent = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_status;
    logic m_active;
    logic [1:0] m_play_state_now;
    logic [31:0] m_consumed_count;

    voice_wave_buffer_sequencer dut (.*);

    // predicted voice state
    logic [2:0] p_chan_count;
    logic [1:0] p_format;
    logic p_flush_en;
    logic [1:0] p_state, p_prior;
    logic [NSLOT-1:0] p_sent;
    logic [NSLOT-1:0] p_valid [NCHAN];
    logic [1:0] p_ring [NCHAN];
    logic [31:0] p_consumed [NCHAN];
    logic [7:0] p_pending;
    logic [1:0] p_head;
    logic p_fresh;

    voice_res_t expected_results[$];
    int errors = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;
    bit in_reset = 1'b1;

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (s_valid && s_ready || m_valid && m_ready || cfg_valid && cfg_ready) begin
            idle_cycles <= 0;
        end else if (!in_reset) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic int driven_channels();
        return (p_chan_count > NCHAN) ? NCHAN : int'(p_chan_count);
    endfunction

    function automatic logic [33:0] byte_position(logic [31:0] off);
        logic [33:0] u;
        logic [33:0] r;
        u = {2'b00, off};
        case (p_format)
            vwbs_pkg::FMT_PCM16: return u * 2;
            vwbs_pkg::FMT_FLOAT: return u * 4;
            vwbs_pkg::FMT_ADPCM: begin
                r = u % 14;
                return (u / 14) * 8 + ((r == 0) ? 0 : r / 2 + 1 + r % 2);
            end
            default: return 0;
        endcase
    endfunction

    function automatic void reset_voice_model();
        p_chan_count = 3'd1;
        p_format = vwbs_pkg::FMT_PCM16;
        p_flush_en = 1'b1;
        p_state = vwbs_pkg::PS_STOPPED;
        p_prior = vwbs_pkg::PS_STOPPED;
        p_sent = '1;
        for (int c = 0; c < NCHAN; c++) begin
            p_valid[c] = '0;
            p_ring[c] = '0;
            p_consumed[c] = '0;
        end
        p_pending = '0;
        p_head = '0;
        p_fresh = 1'b0;
    endfunction

    function automatic voice_res_t predict_voice_step(voice_req_t r);
        voice_res_t res;
        int n;
        int w;
        logic [8:0] sum;
        n = driven_channels();
        res = '0;
        case (r.req_type)
            vwbs_pkg::REQ_UPDATE: begin
                p_prior = p_state;
                if (r.play_request == vwbs_pkg::PLAY_START) p_state = vwbs_pkg::PS_STARTED;
                else if (r.play_request == vwbs_pkg::PLAY_STOP) begin
                    if (p_state != vwbs_pkg::PS_STOPPED) p_state = vwbs_pkg::PS_REQSTOP;
                end else if (r.play_request == vwbs_pkg::PLAY_PAUSE)
                    p_state = vwbs_pkg::PS_PAUSED;
                p_head = r.head_index;
                if (p_flush_en) begin
                    sum = {1'b0, p_pending} + {1'b0, r.flush_add};
                    p_pending = (sum > 255) ? 8'd255 : sum[7:0];
                end
                if (r.new_voice) begin
                    p_sent = '1;
                    for (int c = 0; c < n; c++) p_valid[c] = '0;
                    p_fresh = 1'b1;
                end
            end
            vwbs_pkg::REQ_WRITE: begin
                if (r.already_sent) res.status = vwbs_pkg::ST_SKIPPED;
                else if (r.first_sample[31] || r.last_sample[31])
                    res.status = vwbs_pkg::ST_INVALID;
                else if (p_format != vwbs_pkg::FMT_OTHER &&
                         (byte_position(r.first_sample) > {2'b00, r.buffer_size} ||
                          byte_position(r.last_sample) > {2'b00, r.buffer_size}))
                    res.status = vwbs_pkg::ST_INVALID;
                else begin
                    res.status = vwbs_pkg::ST_OK;
                    p_sent[r.slot] = 1'b0;
                end
            end
            vwbs_pkg::REQ_GEN: begin
                if (p_fresh) begin
                    for (int c = 0; c < n; c++) begin
                        p_valid[c] = '0;
                        p_ring[c] = '0;
                        p_consumed[c] = '0;
                    end
                    p_fresh = 1'b0;
                end
                w = p_head;
                for (int i = 0; i < p_pending; i++) begin
                    p_sent[w] = 1'b1;
                    for (int c = 0; c < n; c++) begin
                        if (p_ring[c] == w) begin
                            p_ring[c] = 2'((w + 1) % NSLOT);
                            p_consumed[c]++;
                        end
                        p_valid[c][w] = 1'b0;
                    end
                    w = (w + 1) % NSLOT;
                end
                p_pending = '0;
                if (p_state == vwbs_pkg::PS_STARTED) begin
                    for (int i = 0; i < NSLOT; i++) begin
                        if (!p_sent[i]) begin
                            for (int c = 0; c < n; c++) p_valid[c][i] = 1'b1;
                            p_sent[i] = 1'b1;
                        end
                    end
                    res.active = (p_valid[0] != 0);
                end else if (p_state == vwbs_pkg::PS_REQSTOP) begin
                    for (int i = 0; i < NSLOT; i++) begin
                        p_sent[i] = 1'b1;
                        for (int c = 0; c < n; c++) begin
                            if (p_valid[c][i]) begin
                                p_ring[c] = p_ring[c] + 2'd1;
                                p_consumed[c]++;
                            end
                            p_valid[c][i] = 1'b0;
                        end
                    end
                    p_state = vwbs_pkg::PS_STOPPED;
                    res.active = (p_prior == vwbs_pkg::PS_STARTED);
                end else begin
                    res.active = (p_prior == vwbs_pkg::PS_STARTED);
                end
            end
            default: ;
        endcase
        res.play_state_now = p_state;
        res.consumed_count = p_fresh ? 32'd0 : p_consumed[0];
        return res;
    endfunction

    task automatic send_request(voice_req_t r);
        int gap;
        gap = $urandom_range(0, 8);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= r.req_type;
        s_play_request <= r.play_request;
        s_flush_add <= r.flush_add;
        s_head_index <= r.head_index;
        s_new_voice <= r.new_voice;
        s_slot <= r.slot;
        s_first_sample <= r.first_sample;
        s_last_sample <= r.last_sample;
        s_buffer_size <= r.buffer_size;
        s_already_sent <= r.already_sent;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(predict_voice_step(r));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [2:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            vwbs_pkg::CFG_CHANNEL_COUNT: p_chan_count = value;
            vwbs_pkg::CFG_SAMPLE_FORMAT: p_format = value[1:0];
            vwbs_pkg::CFG_FLUSH_ENABLE: p_flush_en = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [2:0] chans, logic [1:0] fmt, logic fl);
        drain_results();
        write_register(vwbs_pkg::CFG_CHANNEL_COUNT, chans);
        write_register(vwbs_pkg::CFG_SAMPLE_FORMAT, {1'b0, fmt});
        write_register(vwbs_pkg::CFG_FLUSH_ENABLE, {2'b0, fl});
    endtask

    // receiver side: random stalls, long hold-off on request
    initial begin
        int stall;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
            end else begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
                if (stall != 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_ready <= 1'b1;
                do @(posedge aclk); while (!m_valid);
            end
        end
    end

    always @(posedge aclk) begin
        voice_res_t exp;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                exp = expected_results.pop_front();
                if (m_status !== exp.status) begin
                    $error("status exp %0d got %0d", exp.status, m_status); errors++;
                end
                if (m_active !== exp.active) begin
                    $error("active exp %0d got %0d", exp.active, m_active); errors++;
                end
                if (m_play_state_now !== exp.play_state_now) begin
                    $error("play_state_now exp %0d got %0d", exp.play_state_now,
                           m_play_state_now);
                    errors++;
                end
                if (m_consumed_count !== exp.consumed_count) begin
                    $error("consumed_count exp %0d got %0d", exp.consumed_count,
                           m_consumed_count);
                    errors++;
                end
            end
        end
    end

    function automatic voice_req_t random_request();
        voice_req_t r;
        int k;
        r = '0;
        r.play_request = 2'($urandom_range(0, 3));
        r.flush_add = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
        r.head_index = 2'($urandom_range(0, 3));
        r.new_voice = ($urandom_range(0, 7) == 0);
        r.slot = 2'($urandom_range(0, 3));
        r.already_sent = ($urandom_range(0, 7) == 0);
        r.buffer_size = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 4096);
        k = $urandom_range(0, 9);
        r.first_sample = (k == 0) ? $urandom : $urandom_range(0, 2100);
        k = $urandom_range(0, 9);
        r.last_sample = (k == 0) ? $urandom : $urandom_range(0, 2100);
        k = $urandom_range(0, 19);
        r.req_type = (k < 5) ? vwbs_pkg::REQ_UPDATE : (k < 12) ? vwbs_pkg::REQ_WRITE :
                     (k < 19) ? vwbs_pkg::REQ_GEN : vwbs_pkg::REQ_NOP;
        return r;
    endfunction

    function automatic voice_req_t make_req(logic [1:0] t, logic [1:0] play, logic [7:0] fl,
                                            logic nv, logic [31:0] so, logic [31:0] eo,
                                            logic [31:0] sz, logic skip);
        voice_req_t r;
        r = '0;
        r.req_type = t; r.play_request = play; r.flush_add = fl; r.new_voice = nv;
        r.first_sample = so; r.last_sample = eo; r.buffer_size = sz; r.already_sent = skip;
        r.head_index = 2'($urandom_range(0, 3)); r.slot = 2'($urandom_range(0, 3));
        return r;
    endfunction

    task automatic test_directed();
        send_request(make_req(vwbs_pkg::REQ_GEN, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(vwbs_pkg::REQ_UPDATE, vwbs_pkg::PLAY_START, 8'd255, 1, 0, 0, 0, 0));
        send_request(make_req(vwbs_pkg::REQ_UPDATE, vwbs_pkg::PLAY_START, 8'd255, 0, 0, 0, 0, 0));
        send_request(make_req(vwbs_pkg::REQ_WRITE, 0, 0, 0, 0, 100, 200, 0));
        send_request(make_req(vwbs_pkg::REQ_WRITE, 0, 0, 0, 0, 101, 200, 0));
        send_request(make_req(vwbs_pkg::REQ_WRITE, 0, 0, 0, 32'h8000_0000, 0,
                              32'hffff_ffff, 0));
        send_request(make_req(vwbs_pkg::REQ_WRITE, 0, 0, 0, 0, 32'h7fff_ffff,
                              32'hffff_ffff, 0));
        send_request(make_req(vwbs_pkg::REQ_WRITE, 0, 0, 0, 0, 0, 0, 1));
        send_request(make_req(vwbs_pkg::REQ_GEN, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(vwbs_pkg::REQ_UPDATE, 2'd0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(vwbs_pkg::REQ_WRITE, 0, 0, 0, 5, 9, 32, 0));
        send_request(make_req(vwbs_pkg::REQ_GEN, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(vwbs_pkg::REQ_UPDATE, 2'd3, 8'd2, 0, 0, 0, 0, 0));
        send_request(make_req(vwbs_pkg::REQ_UPDATE, vwbs_pkg::PLAY_PAUSE, 0, 0, 0, 0, 0, 0));
        send_request(make_req(vwbs_pkg::REQ_GEN, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(vwbs_pkg::REQ_UPDATE, vwbs_pkg::PLAY_STOP, 0, 0, 0, 0, 0, 0));
        send_request(make_req(vwbs_pkg::REQ_GEN, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(vwbs_pkg::REQ_UPDATE, vwbs_pkg::PLAY_STOP, 0, 0, 0, 0, 0, 0));
        send_request(make_req(vwbs_pkg::REQ_NOP, 2'd3, 8'hff, 1, 32'hffff_ffff, 32'hffff_ffff,
                              32'hffff_ffff, 1));
    endtask

    task automatic test_formats();
        set_config(3'd6, vwbs_pkg::FMT_ADPCM, 1'b1);
        send_request(make_req(vwbs_pkg::REQ_WRITE, 0, 0, 0, 14, 15, 8, 0));
        send_request(make_req(vwbs_pkg::REQ_WRITE, 0, 0, 0, 14, 13, 16, 0));
        set_config(3'd0, vwbs_pkg::FMT_FLOAT, 1'b0);
        send_request(make_req(vwbs_pkg::REQ_UPDATE, vwbs_pkg::PLAY_START, 8'd7, 1, 0, 0, 0, 0));
        send_request(make_req(vwbs_pkg::REQ_WRITE, 0, 0, 0, 3, 4, 16, 0));
        send_request(make_req(vwbs_pkg::REQ_GEN, 0, 0, 0, 0, 0, 0, 0));
        set_config(3'd7, vwbs_pkg::FMT_OTHER, 1'b1);
        send_request(make_req(vwbs_pkg::REQ_WRITE, 0, 0, 0, 32'h7fff_ffff, 1, 0, 0));
        send_request(make_req(vwbs_pkg::REQ_GEN, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random_sessions(int count);
        voice_req_t r;
        for (int i = 0; i < count; i++) begin
            if (i % 350 == 349)
                set_config(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                           1'($urandom_range(0, 1)));
            r = random_request();
            send_request(r);
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
            test_random_sessions(20);
        join
    endtask

    initial begin
        reset_voice_model();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        in_reset = 1'b0;
        test_directed();
        test_formats();
        set_config(3'd1, vwbs_pkg::FMT_PCM16, 1'b1);
        test_backpressure();
        test_random_sessions(1700);
        drain_results();
        if (errors == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: voice_wave_buffer_sequencer.f
rtl/vwbs_pkg.sv
rtl/vwbs_ctrl.sv
rtl/vwbs_datapath.sv
rtl/voice_wave_buffer_sequencer.sv
tb/voice_wave_buffer_sequencer_tb.sv
